@@ design/ipsd_pkg.sv @@
// ============================================================================
// ipsd_pkg
// Shared types and constants for the inverse Park / SVPWM duty block.
// ============================================================================
`default_nettype none

package ipsd_pkg;

    localparam int ANGLE_BITS         = 16;
    localparam int SINE_TABLE_ENTRIES = 256;
    localparam int VOLT_BITS          = 16;

    localparam int PERIOD_W = 16;
    localparam int LIMIT_W  = 15;
    localparam int DUTY_W   = 15;
    localparam int SECTOR_W = 3;
    localparam int SIN_W    = 17;

    localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;
    localparam logic signed [63:0] ONE_Q15   = 64'sd32768;

    typedef enum logic [0:0] {
        REG_PWM_PERIOD    = 1'd0,
        REG_VOLTAGE_LIMIT = 1'd1
    } t_reg_idx;

    typedef struct packed {
        logic signed [VOLT_BITS-1:0] volt_d;
        logic signed [VOLT_BITS-1:0] volt_q;
        logic [ANGLE_BITS-1:0]       elec_angle;
    } t_cmd;

    typedef struct packed {
        logic [DUTY_W-1:0]   duty_u;
        logic [DUTY_W-1:0]   duty_v;
        logic [DUTY_W-1:0]   duty_w;
        logic [SECTOR_W-1:0] sector;
    } t_duty;

    // Quarter-wave sine, round(32768*sin(pi/2*k/n)), from an integer Taylor series.
    function automatic logic [SIN_W-1:0] sine_entry(input int unsigned k,
                                                    input int unsigned n);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x = (64'd1686629713 * 64'(k)) / 64'(n);
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int i = 1; i <= 7; i++) begin
            term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
            if (i % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        r = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[SIN_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ design/ipsd_if.sv @@
// ============================================================================
// ipsd_if
// Valid/ready stream interface with a generic payload.
// ============================================================================
`default_nettype none

interface ipsd_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/inverse_park_svpwm_duty_top.sv @@
// ============================================================================
// inverse_park_svpwm_duty_top
// Clamp, inverse Park rotation, sextant search and SVPWM compare counts.
// ============================================================================
// Five-stage pipeline, one item per clock while the output
// is taken. Stages: clamp + table lookup, rotation products, alpha*sqrt3,
// sextant and phase sums, duty offset and saturation. All stages advance
// together: while the output item waits every stage holds, bubbles included.
// Registers are written over APB at byte address 4*index; the limit is used
// in the first stage and the period in the last, so write them only while no
// item is in flight.
`default_nettype none

module inverse_park_svpwm_duty_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ipsd_if.sink             i_in,
    ipsd_if.source           o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import ipsd_pkg::*;

    localparam int N     = SINE_TABLE_ENTRIES;
    localparam int NB    = $clog2(N);
    localparam int STEPW = NB + 2;
    localparam int NS    = 5;

    // ---- table
    logic [SIN_W-1:0] sin_tab [0:N];
    always_comb begin
        for (int k = 0; k <= N; k++) begin
            sin_tab[k] = sine_entry(k, N);
        end
    end

    // ---- config
    logic [PERIOD_W-1:0] r_period;
    logic [LIMIT_W-1:0]  r_limit;
    logic                cfg_we;
    t_reg_idx            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 16'd4000;
            r_limit  <= 15'd1000;
        end else if (cfg_we && paddr[1:0] == 2'd0) begin
            case (cfg_idx)
                REG_PWM_PERIOD:    r_period <= pwdata[PERIOD_W-1:0];
                REG_VOLTAGE_LIMIT: r_limit  <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        case (cfg_idx)
            REG_PWM_PERIOD:    prdata = 32'(r_period);
            REG_VOLTAGE_LIMIT: prdata = 32'(r_limit);
            default:           prdata = 32'd0;
        endcase
        if (paddr[1:0] != 2'd0) begin
            prdata = 32'd0;
        end
    end

    // ---- pipeline control
    logic [NS-1:0] r_vld;
    logic          adv;
    assign adv         = !r_vld[NS-1] || o_out.ready;
    assign i_in.ready  = adv;
    assign o_out.valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-2:0], i_in.valid};
        end
    end

    // ---- stage 1: clamp and lookup
    logic signed [VOLT_BITS-1:0] vd_in, vq_in;
    logic signed [16:0] lim_p, lim_n, n_d, n_q;
    logic [ANGLE_BITS-1:0] ang;
    logic [STEPW-1:0] stp, cstp;
    logic signed [SIN_W:0] n_s, n_c;

    function automatic logic signed [SIN_W:0] sine_at(input logic [STEPW-1:0] st,
                                                      input logic [SIN_W-1:0] tab [0:N]);
        logic [NB:0] off;
        logic [SIN_W-1:0] mag;
        off = {1'b0, st[NB-1:0]};
        if (st[NB]) begin
            mag = tab[(NB+1)'(N) - off];
        end else begin
            mag = tab[off];
        end
        if (st[NB+1]) begin
            return -$signed({1'b0, mag});
        end
        return $signed({1'b0, mag});
    endfunction

    always_comb begin
        vd_in = i_in.data.volt_d[VOLT_BITS-1:0];
        vq_in = i_in.data.volt_q[VOLT_BITS-1:0];
        lim_p = $signed({2'b00, r_limit});
        lim_n = -lim_p;
        n_d = 17'(vd_in);
        if (n_d > lim_p) n_d = lim_p;
        if (n_d < lim_n) n_d = lim_n;
        n_q = 17'(vq_in);
        if (n_q > lim_p) n_q = lim_p;
        if (n_q < lim_n) n_q = lim_n;
        ang  = i_in.data.elec_angle[ANGLE_BITS-1:0];
        stp  = STEPW'(({ang, {STEPW{1'b0}}} >> ANGLE_BITS));
        cstp = stp + STEPW'(N);
        n_s  = sine_at(stp, sin_tab);
        n_c  = sine_at(cstp, sin_tab);
    end

    logic signed [16:0]    r_d1, r_q1;
    logic signed [SIN_W:0] r_s1, r_c1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d1 <= n_d; r_q1 <= n_q; r_s1 <= n_s; r_c1 <= n_c;
        end
    end

    // ---- stage 2: rotation
    logic signed [35:0] r_al2, r_be2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_al2 <= 36'(r_d1) * 36'(r_c1) - 36'(r_q1) * 36'(r_s1);
            r_be2 <= 36'(r_d1) * 36'(r_s1) + 36'(r_q1) * 36'(r_c1);
        end
    end

    // ---- stage 3: alpha*sqrt3, truncated toward zero
    logic signed [67:0] prod3;
    logic signed [67:0] bias3;
    logic signed [39:0] r_al3, r_be3, r_a33;
    always_comb begin
        prod3 = 68'(r_al2) * 68'(SQRT3_Q30);
        bias3 = prod3[67] ? (prod3 + 68'sd1073741823) : prod3;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_al3 <= 40'(r_al2);
            r_be3 <= 40'(r_be2);
            r_a33 <= 40'(bias3 >>> 30);
        end
    end

    // ---- stage 4: sextant and phase values (doubled)
    logic signed [39:0] ta, tb, u2, v2, w2, one;
    logic [SECTOR_W-1:0] sec;
    always_comb begin
        one = 40'(ONE_Q15);
        if (r_be3 > 0) begin
            if (r_al3 > 0) sec = (r_be3 > r_a33) ? 3'd2 : 3'd1;
            else           sec = (-r_be3 > r_a33) ? 3'd3 : 3'd2;
        end else begin
            if (r_al3 > 0) sec = (-r_be3 > r_a33) ? 3'd5 : 3'd6;
            else           sec = (r_be3 > r_a33) ? 3'd4 : 3'd5;
        end
        ta = '0; tb = '0; u2 = '0; v2 = '0; w2 = '0;
        case (sec)
            3'd1: begin
                ta = -r_a33 + r_be3; tb = -2 * r_be3;
                u2 = one - ta - tb; v2 = u2 + 2 * ta; w2 = v2 + 2 * tb;
            end
            3'd2: begin
                ta = -r_a33 - r_be3; tb = r_a33 - r_be3;
                v2 = one - ta - tb; u2 = v2 + 2 * tb; w2 = u2 + 2 * ta;
            end
            3'd3: begin
                ta = -2 * r_be3; tb = r_a33 + r_be3;
                v2 = one - ta - tb; w2 = v2 + 2 * ta; u2 = w2 + 2 * tb;
            end
            3'd4: begin
                ta = r_a33 - r_be3; tb = 2 * r_be3;
                w2 = one - ta - tb; v2 = w2 + 2 * tb; u2 = v2 + 2 * ta;
            end
            3'd5: begin
                ta = r_a33 + r_be3; tb = -r_a33 + r_be3;
                w2 = one - ta - tb; u2 = w2 + 2 * ta; v2 = u2 + 2 * tb;
            end
            default: begin
                ta = 2 * r_be3; tb = -r_a33 - r_be3;
                u2 = one - ta - tb; w2 = u2 + 2 * tb; v2 = w2 + 2 * ta;
            end
        endcase
    end

    logic signed [39:0] r_u4, r_v4, r_w4;
    logic [SECTOR_W-1:0] r_sec4;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_u4 <= u2; r_v4 <= v2; r_w4 <= w2; r_sec4 <= sec;
        end
    end

    // ---- stage 5: duty
    function automatic logic [DUTY_W-1:0] to_duty(input logic signed [39:0] x,
                                                  input logic [PERIOD_W-1:0] per);
        logic signed [39:0] q;
        logic signed [39:0] d;
        logic signed [39:0] hi;
        q  = (x[39] ? (x + 40'sd131071) : x) >>> 17;
        d  = q + 40'($unsigned(per >> 2));
        hi = 40'($unsigned(per >> 1));
        if (d < 0)  d = '0;
        if (d > hi) d = hi;
        return d[DUTY_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_out.data.duty_u <= to_duty(r_u4, r_period);
            o_out.data.duty_v <= to_duty(r_v4, r_period);
            o_out.data.duty_w <= to_duty(r_w4, r_period);
            o_out.data.sector <= r_sec4;
        end
    end

endmodule

`default_nettype wire

@@ design/ipsd_checker.sv @@
// ============================================================================
// ipsd_checker
// Port-level checks of the inverse Park / SVPWM duty block.
// ============================================================================
`default_nettype none

module ipsd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  out_sector,
    input wire logic        pready
);
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_sector >= 3'd1 && out_sector <= 3'd6))
        else $error("sector out of range");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped under stall");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind inverse_park_svpwm_duty_top ipsd_checker u_ipsd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (i_in.valid),
    .in_ready   (i_in.ready),
    .out_valid  (o_out.valid),
    .out_ready  (o_out.ready),
    .out_sector (o_out.data.sector),
    .pready     (pready)
);

`default_nettype wire

@@ dv/ipsd_tb_pkg.sv @@
// ============================================================================
// ipsd_tb_pkg
// Constants for the inverse Park / SVPWM duty testbench.
// ============================================================================
`default_nettype none

package ipsd_tb_pkg;

    localparam int     TAB_N     = ipsd_pkg::SINE_TABLE_ENTRIES;
    localparam longint ROOT3_Q30 = 64'sd1859775393;
    localparam longint UNIT_Q15  = 64'sd32768;
    localparam int     CYC_LIMIT = 1000000;

endpackage

`default_nettype wire

@@ dv/inverse_park_svpwm_duty_top_test.sv @@
// ============================================================================
// inverse_park_svpwm_duty_top_test
// Streams voltage/angle items through the duty block under random idling and
// backpressure, over several period/limit settings, and compares each duty
// item with an internal fixed-point inverse Park / SVPWM predictor.
// ============================================================================
`default_nettype none

module inverse_park_svpwm_duty_top_test;
    import ipsd_pkg::*;
    import ipsd_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ipsd_if #(.T(t_cmd))  cmd_if ();
    ipsd_if #(.T(t_duty)) duty_if ();

    inverse_park_svpwm_duty_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (duty_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    longint sin_tab [0:TAB_N];
    longint period_m = 4000;
    longint limit_m  = 1000;
    t_cmd   cmd_q [$];
    t_duty  duty_exp_q [$];
    int     err_cnt = 0;
    int     cyc_cnt = 0;
    bit     idle_en = 1'b1;
    bit     hold_go = 1'b0;
    int     hold_cnt = 0;
    int     send_gap = 0;
    int     recv_gap = 0;

    initial begin
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        duty_if.ready = 1'b0;
    end

    function automatic void build_sin_tab();
        longint unsigned x, x2, term, sum, r;
        for (int k = 0; k <= TAB_N; k++) begin
            x = (64'd1686629713 * longint'(k)) / TAB_N;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                sum = (n % 2 == 1) ? sum - term : sum + term;
            end
            r = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
            sin_tab[k] = (r > 32768) ? 32768 : r;
        end
    endfunction

    function automatic longint sine_of(int step);
        int     quad;
        int     off;
        longint mag;
        quad = (step / TAB_N) % 4;
        off = step % TAB_N;
        mag = quad[0] ? sin_tab[TAB_N - off] : sin_tab[off];
        return quad[1] ? -mag : mag;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [14:0] duty_count(longint dbl);
        longint d;
        d = dbl / (UNIT_Q15 * 4) + period_m / 4;
        d = clampl(d, 0, period_m / 2);
        return d[14:0];
    endfunction

    function automatic t_duty svpwm_predict(t_cmd c);
        longint d, q, s, co, alpha, beta, a3, u2, v2, w2, ta, tb;
        int     step;
        int     sec;
        t_duty  r;
        d = clampl(longint'(c.volt_d), -limit_m, limit_m);
        q = clampl(longint'(c.volt_q), -limit_m, limit_m);
        step = int'(c.elec_angle) >> 6;
        s = sine_of(step);
        co = sine_of((step + TAB_N) % (4 * TAB_N));
        alpha = d * co - q * s;
        beta = d * s + q * co;
        a3 = (alpha * ROOT3_Q30) / (64'sd1 << 30);
        if (beta > 0) begin
            if (alpha > 0) sec = (beta > a3) ? 2 : 1;
            else sec = (-beta > a3) ? 3 : 2;
        end else begin
            if (alpha > 0) sec = (-beta > a3) ? 5 : 6;
            else sec = (beta > a3) ? 4 : 5;
        end
        case (sec)
            1: begin
                ta = -a3 + beta; tb = -2 * beta;
                u2 = UNIT_Q15 - ta - tb; v2 = u2 + 2 * ta; w2 = v2 + 2 * tb;
            end
            2: begin
                ta = -a3 - beta; tb = a3 - beta;
                v2 = UNIT_Q15 - ta - tb; u2 = v2 + 2 * tb; w2 = u2 + 2 * ta;
            end
            3: begin
                ta = -2 * beta; tb = a3 + beta;
                v2 = UNIT_Q15 - ta - tb; w2 = v2 + 2 * ta; u2 = w2 + 2 * tb;
            end
            4: begin
                ta = a3 - beta; tb = 2 * beta;
                w2 = UNIT_Q15 - ta - tb; v2 = w2 + 2 * tb; u2 = v2 + 2 * ta;
            end
            5: begin
                ta = a3 + beta; tb = -a3 + beta;
                w2 = UNIT_Q15 - ta - tb; u2 = w2 + 2 * ta; v2 = u2 + 2 * tb;
            end
            default: begin
                ta = 2 * beta; tb = -a3 - beta;
                u2 = UNIT_Q15 - ta - tb; w2 = u2 + 2 * tb; v2 = w2 + 2 * ta;
            end
        endcase
        r.duty_u = duty_count(u2);
        r.duty_v = duty_count(v2);
        r.duty_w = duty_count(w2);
        r.sector = sec[2:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_cnt++;
    endtask

    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_PWM_PERIOD) period_m = val[15:0];
        else limit_m = val[14:0];
    endtask

    function automatic logic signed [15:0] rand_volt();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sh7fff;
        if (r == 1) return 16'sh8000;
        if (r < 5) return 16'($signed(int'(limit_m)) + $signed($urandom_range(0, 4)) - 2);
        if (r < 7) return -16'($signed(int'(limit_m)) + $signed($urandom_range(0, 4)) - 2);
        return 16'($urandom);
    endfunction

    task automatic push_random(int n);
        t_cmd c;
        repeat (n) begin
            c.volt_d = rand_volt();
            c.volt_q = rand_volt();
            c.elec_angle = 16'($urandom);
            cmd_q.push_back(c);
        end
    endtask

    task automatic drain();
        while (cmd_q.size() != 0 || cmd_if.valid || duty_exp_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
    endtask

    // stimulus feed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                cmd_if.valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                cmd_if.data <= cmd_q[0];
                duty_exp_q.push_back(svpwm_predict(cmd_q[0]));
                void'(cmd_q.pop_front());
                cmd_if.valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // long receive hold-off
    always @(posedge i_clk) begin
        if (hold_go && hold_cnt < 300) hold_cnt <= hold_cnt + 1;
    end

    // result check
    always @(posedge i_clk) begin
        t_duty got, want;
        if (i_rst_n && duty_if.valid && duty_if.ready) begin
            got = t_duty'(duty_if.data);
            if (duty_exp_q.size() == 0) begin
                report("unexpected item", got.sector, 0);
            end else begin
                want = duty_exp_q.pop_front();
                if (got.duty_u !== want.duty_u) report("duty_u", got.duty_u, want.duty_u);
                if (got.duty_v !== want.duty_v) report("duty_v", got.duty_v, want.duty_v);
                if (got.duty_w !== want.duty_w) report("duty_w", got.duty_w, want.duty_w);
                if (got.sector !== want.sector) report("sector", got.sector, want.sector);
            end
        end
        if (!i_rst_n || (hold_go && hold_cnt < 300)) begin
            duty_if.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            duty_if.ready <= 1'b0;
        end else begin
            duty_if.ready <= 1'b1;
            recv_gap <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= CYC_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_cmd c;
        build_sin_tab();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, quadrant edges, zero vector
        c = '{16'sh0000, 16'sh0000, 16'h0000}; cmd_q.push_back(c);
        c = '{16'sh7fff, 16'sh7fff, 16'hffff}; cmd_q.push_back(c);
        c = '{16'sh8000, 16'sh8000, 16'h0000}; cmd_q.push_back(c);
        c = '{16'sh7fff, 16'sh8000, 16'h4000}; cmd_q.push_back(c);
        c = '{16'sh8000, 16'sh7fff, 16'h8000}; cmd_q.push_back(c);
        c = '{16'sd1000, 16'sd0, 16'hc000}; cmd_q.push_back(c);
        c = '{16'sd0, 16'sd1000, 16'h003f}; cmd_q.push_back(c);
        c = '{16'sd0, -16'sd1000, 16'h0040}; cmd_q.push_back(c);
        c = '{16'sd999, -16'sd1001, 16'h2aab}; cmd_q.push_back(c);
        c = '{16'sd1001, 16'sd999, 16'h5555}; cmd_q.push_back(c);
        c = '{-16'sd1000, 16'sd0, 16'h1555}; cmd_q.push_back(c);
        c = '{16'sd0, 16'sd0, 16'hffc0}; cmd_q.push_back(c);
        for (int k = 0; k < 6; k++) begin
            c = '{16'sd0, 16'sd800, 16'(k * 10923 + 5461)};
            cmd_q.push_back(c);
        end
        push_random(200);
        drain();

        reg_write(REG_PWM_PERIOD, 32'd4);
        reg_write(REG_VOLTAGE_LIMIT, 32'd0);
        push_random(150);
        drain();

        // full range, then a long receive stall with no idling
        idle_en = 1'b0;
        reg_write(REG_PWM_PERIOD, 32'd65534);
        reg_write(REG_VOLTAGE_LIMIT, 32'd32767);
        push_random(200);
        hold_go <= 1'b1;
        drain();
        idle_en = 1'b1;

        reg_write(REG_PWM_PERIOD, 32'd2);
        reg_write(REG_VOLTAGE_LIMIT, 32'd300);
        push_random(100);
        drain();

        for (int p = 0; p < 3; p++) begin
            reg_write(REG_PWM_PERIOD, $urandom_range(4, 65534));
            reg_write(REG_VOLTAGE_LIMIT, $urandom_range(0, 32767));
            push_random(150);
            drain();
        end

        reg_write(REG_PWM_PERIOD, 32'd4000);
        reg_write(REG_VOLTAGE_LIMIT, 32'd1000);
        push_random(150);
        drain();

        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
